/* design/tpda_pkg.sv */
package tpda_pkg;

  // Entries held by each of the four FIFOs (east-low, east-high, west-low, west-high)
  localparam int QUEUE_DEPTH  = 16;
  // Run of grants to one side after which the other side takes precedence
  localparam int STREAK_LIMIT = 3;

  localparam int NUM_FIFOS = 4;
  localparam int FIFO_W    = $clog2(NUM_FIFOS);
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_D   = NUM_FIFOS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(STORE_D);
  localparam int ID_W      = 8;

  // Request kinds
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_GRANT   = 1'b1;

  // Sides as carried on the ports
  localparam logic DIR_EAST = 1'b0;
  localparam logic DIR_WEST = 1'b1;

  // Side recorded in the grant history
  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_EAST = 2'd1,
    SIDE_WEST = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_GRANTED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Outcome of the grant decision
  typedef struct packed {
    logic any;   // at least one requester waits
    logic side;  // winning side, DIR_EAST or DIR_WEST
    logic prio;  // head priority of the winning side
  } pick_t;

  // FIFO index: side in the upper bit, priority in the lower bit
  function automatic logic [FIFO_W-1:0] fifo_idx(input logic side, input logic prio);
    fifo_idx = {side, prio};
  endfunction

endpackage

/* design/tpda_pick.sv */
module tpda_pick
  import tpda_pkg::*;
(
  input  logic [NUM_FIFOS-1:0] nonempty_i,
  input  side_e                history_i [STREAK_LIMIT],
  output pick_t                pick_o
);

  logic e_ok, w_ok, e_high, w_high;
  logic streak_east, streak_west;

  always_comb begin
    streak_east = 1'b1;
    streak_west = 1'b1;
    for (int i = 0; i < STREAK_LIMIT; i++) begin
      if (history_i[i] != SIDE_EAST) streak_east = 1'b0;
      if (history_i[i] != SIDE_WEST) streak_west = 1'b0;
    end
  end

  assign e_high = nonempty_i[fifo_idx(DIR_EAST, 1'b1)];
  assign w_high = nonempty_i[fifo_idx(DIR_WEST, 1'b1)];
  assign e_ok   = e_high | nonempty_i[fifo_idx(DIR_EAST, 1'b0)];
  assign w_ok   = w_high | nonempty_i[fifo_idx(DIR_WEST, 1'b0)];

  always_comb begin
    pick_o.any = e_ok | w_ok;
    // starvation guard first, then lone side, then head priority, then alternation
    if (streak_west && e_ok) begin
      pick_o.side = DIR_EAST;
    end else if (streak_east && w_ok) begin
      pick_o.side = DIR_WEST;
    end else if (w_ok && !e_ok) begin
      pick_o.side = DIR_WEST;
    end else if (e_ok && !w_ok) begin
      pick_o.side = DIR_EAST;
    end else if (w_high && !e_high) begin
      pick_o.side = DIR_WEST;
    end else if (e_high && !w_high) begin
      pick_o.side = DIR_EAST;
    end else begin
      pick_o.side = (history_i[0] == SIDE_WEST) ? DIR_EAST : DIR_WEST;
    end
    pick_o.prio = (pick_o.side == DIR_WEST) ? w_high : e_high;
  end

endmodule

/* design/two_way_priority_dispatch_arbiter.sv */
// Two-side priority dispatch arbiter.
//
// Input channel (in_valid_i / in_ready_o) carries one item: an arrival that
// queues a requester id on the east or west side at high or low priority, or
// a grant request that removes one requester. Output channel (out_valid_o /
// out_ready_i) returns exactly one result item per input item, in order:
// queued, dropped (that side/priority FIFO full), granted (with id, side and
// priority) or empty (nothing waiting).
//
// From acceptance to result an item passes an input register, then the
// decision with the queue-store access, then the result register. One
// item is taken every cycle unless the output stalls; the single-port
// queue store, with a registered read used once per item, sets that rate.
//
// Reset empties every FIFO (pointers and counts cleared) and clears the grant
// history; the store contents are left as they are. When the receiver stalls,
// the result register holds, the input register stays full behind it, and
// in_ready_o drops once both are occupied. No clearing pass is needed.
module two_way_priority_dispatch_arbiter
  import tpda_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [ID_W-1:0] train_id_i,
  input  logic            direction_i,
  input  logic            priority_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [ID_W-1:0] granted_train_o,
  output logic            granted_direction_o,
  output logic            granted_priority_o
);

  // Input register
  logic            a_valid_q;
  logic            a_type_q;
  logic [ID_W-1:0] a_id_q;
  logic            a_dir_q;
  logic            a_prio_q;

  // Result register
  logic            b_valid_q;
  status_e         b_status_q, b_status_d;
  logic            b_dir_q, b_dir_d;
  logic            b_prio_q, b_prio_d;
  logic [ID_W-1:0] rdata_q;

  // Queue bookkeeping
  logic [PTR_W-1:0] rd_ptr_q [NUM_FIFOS];
  logic [PTR_W-1:0] rd_ptr_d [NUM_FIFOS];
  logic [PTR_W-1:0] wr_ptr_q [NUM_FIFOS];
  logic [PTR_W-1:0] wr_ptr_d [NUM_FIFOS];
  logic [CNT_W-1:0] count_q  [NUM_FIFOS];
  logic [CNT_W-1:0] count_d  [NUM_FIFOS];
  side_e            hist_q   [STREAK_LIMIT];
  side_e            hist_d   [STREAK_LIMIT];

  // Queue store, one region of QUEUE_DEPTH entries per FIFO
  logic [ID_W-1:0] store_q [STORE_D];

  logic                 a_advance, a_fire, in_fire;
  logic [NUM_FIFOS-1:0] nonempty;
  pick_t                pick;
  logic [FIFO_W-1:0]    arr_f, grt_f, acc_f;
  logic                 arr_full;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_addr;
  logic [PTR_W-1:0]     acc_ptr;

  // Handshakes: the input register moves on whenever the result register
  // is empty or being emptied
  assign a_advance  = !b_valid_q || out_ready_i;
  assign a_fire     = a_valid_q && a_advance;
  assign in_ready_o = !a_valid_q || a_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_type_q <= req_type_i;
      a_id_q   <= train_id_i;
      a_dir_q  <= direction_i;
      a_prio_q <= priority_req_i;
    end
  end

  // Decision
  always_comb begin
    for (int i = 0; i < NUM_FIFOS; i++) begin
      nonempty[i] = (count_q[i] != '0);
    end
  end

  tpda_pick u_pick (
    .nonempty_i (nonempty),
    .history_i  (hist_q),
    .pick_o     (pick)
  );

  assign arr_f    = fifo_idx(a_dir_q, a_prio_q);
  assign grt_f    = fifo_idx(pick.side, pick.prio);
  assign arr_full = (count_q[arr_f] >= CNT_W'(QUEUE_DEPTH));

  assign mem_we   = a_fire && (a_type_q == REQ_ARRIVAL) && !arr_full;
  assign mem_re   = a_fire && (a_type_q == REQ_GRANT) && pick.any;
  assign acc_f    = (a_type_q == REQ_ARRIVAL) ? arr_f : grt_f;
  assign acc_ptr  = (a_type_q == REQ_ARRIVAL) ? wr_ptr_q[arr_f] : rd_ptr_q[grt_f];
  assign mem_addr = ADDR_W'(acc_f) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(acc_ptr);

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    count_d    = count_q;
    hist_d     = hist_q;
    b_status_d = ST_EMPTY;
    b_dir_d    = 1'b0;
    b_prio_d   = 1'b0;
    if (a_type_q == REQ_ARRIVAL) begin
      if (arr_full) begin
        b_status_d = ST_DROPPED;
      end else begin
        b_status_d      = ST_QUEUED;
        wr_ptr_d[arr_f] = (wr_ptr_q[arr_f] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_q[arr_f] + 1'b1;
        count_d[arr_f]  = count_q[arr_f] + 1'b1;
      end
    end else if (pick.any) begin
      b_status_d      = ST_GRANTED;
      b_dir_d         = pick.side;
      b_prio_d        = pick.prio;
      rd_ptr_d[grt_f] = (rd_ptr_q[grt_f] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_q[grt_f] + 1'b1;
      count_d[grt_f]  = count_q[grt_f] - 1'b1;
      // shift the history, newest first
      for (int i = STREAK_LIMIT - 1; i > 0; i--) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = (pick.side == DIR_WEST) ? SIDE_WEST : SIDE_EAST;
    end
  end

  // Commit queue state only when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        count_q[i]  <= '0;
      end
      for (int i = 0; i < STREAK_LIMIT; i++) begin
        hist_q[i] <= SIDE_NONE;
      end
    end else if (a_fire) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      hist_q   <= hist_d;
    end
  end

  // Single-port store; read data is captured straight into the result stage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= a_id_q;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_addr];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_advance) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_status_q <= b_status_d;
      b_dir_q    <= b_dir_d;
      b_prio_q   <= b_prio_d;
    end
  end

  assign out_valid_o         = b_valid_q;
  assign status_o            = b_status_q;
  assign granted_train_o     = (b_status_q == ST_GRANTED) ? rdata_q : '0;
  assign granted_direction_o = b_dir_q;
  assign granted_priority_o  = b_prio_q;

  // Checks
  logic cnt_over;
  always_comb begin
    cnt_over = 1'b0;
    for (int i = 0; i < NUM_FIFOS; i++) begin
      if (count_q[i] > CNT_W'(QUEUE_DEPTH)) cnt_over = 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) !cnt_over)
    else $error("FIFO occupancy above depth");

  a_empty_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
      a_fire && (a_type_q == REQ_GRANT) && !pick.any
      |=> b_valid_q && (b_status_q == ST_EMPTY) && $stable(count_q[0]))
    else $error("grant with nothing waiting did not report empty");

  a_hist_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
      a_fire && (a_type_q == REQ_GRANT) && pick.any
      |=> (b_status_q == ST_GRANTED) &&
          (hist_q[0] == ((b_dir_q == DIR_WEST) ? SIDE_WEST : SIDE_EAST)))
    else $error("grant history does not match granted side");

  a_drop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      a_fire && (a_type_q == REQ_ARRIVAL) && arr_full
      |=> (b_status_q == ST_DROPPED) && $stable(count_q[1]) && $stable(count_q[3]))
    else $error("dropped arrival changed queue state");

endmodule
